>>> rtl/tvcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvcm_pkg: shared types and constants
// Types, widths and defaults for the tetrahedron volume block.
// ----------------------------------------------------------------------------
package tvcm_pkg;

    // The multiplier and accumulator widths are sized for this coordinate width.
    localparam int COORD_BITS = 16;
    localparam int VOLUME_FRAC_BITS_DEF = 8;
    localparam int VOL_WIDTH = 56;
    localparam int ACC_W = 66;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CROSS,
        ST_DOT,
        ST_DIV,
        ST_DONE
    } state_t;

    // Operation codes for the shared multiply-accumulate unit.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ADD,
        OP_SUB
    } mac_op_t;

    typedef struct packed {
        logic    en;
        mac_op_t op;
    } mac_ctrl_t;

endpackage

>>> rtl/tvcm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvcm_mac: shared multiply-accumulate unit
// One signed product per cycle while enabled, loaded into, added to or subtracted from a register.
// ----------------------------------------------------------------------------
module tvcm_mac
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tvcm_pkg::mac_ctrl_t         ctrl,
    input  logic signed [33:0]          a,
    input  logic signed [33:0]          b,
    output logic signed [tvcm_pkg::ACC_W-1:0] acc
);
    import tvcm_pkg::*;

    logic signed [67:0]      prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign prod = a * b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.en)
        begin
            case (ctrl.op)
                OP_LOAD: acc_next = prod[ACC_W-1:0];
                OP_ADD:  acc_next = acc_reg + prod[ACC_W-1:0];
                OP_SUB:  acc_next = acc_reg - prod[ACC_W-1:0];
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> rtl/tetrahedron_volume_cayley_menger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetrahedron_volume_cayley_menger: tetrahedron volume from four vertices
// Forms |triple product| of the edge vectors, equal to sqrt(det/8) of the
// Cayley-Menger matrix, and returns floor(|D| * 2^F / 6) with saturation.
//
//   channel | signals                         | direction
//   input   | in_valid, in_stall, v*_x/y/z    | into block
//   output  | out_valid, out_stall, volume    | out of block
//
// After acceptance the block forms the edge vectors, then the cross product
// on the shared multiplier, then the dot product, then the division by 6,
// taken 16 bits a cycle, and then shows the result. A new transaction is
// not accepted until the last result has been taken: in_stall is high from
// acceptance until the result has been taken. Reset clears control state
// and the MAC accumulator only. A stalled result holds until out_stall drops.
// ----------------------------------------------------------------------------
module tetrahedron_volume_cayley_menger
#(
    parameter int VOLUME_FRAC_BITS = tvcm_pkg::VOLUME_FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v0_x,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v0_y,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v0_z,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v1_x,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v1_y,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v1_z,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v2_x,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v2_y,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v2_z,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v3_x,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v3_y,
    input  logic signed [tvcm_pkg::COORD_BITS-1:0] v3_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tvcm_pkg::VOL_WIDTH-1:0]        volume
);
    import tvcm_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int DW = 64;

    state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [2:0]  bit_reg, bit_next;

    logic signed [COORD_BITS-1:0] p_reg [12];
    logic signed [EW-1:0]         e_reg [9];
    logic signed [33:0]           c_reg [3];
    logic [DW-1:0]                mag_reg;
    logic [DW-1:0]                q_reg, q_next;
    logic [2:0]                   r_reg, r_next;
    logic [VOL_WIDTH-1:0]         vol_reg;

    mac_ctrl_t ctrl;
    logic signed [33:0] mac_a, mac_b;
    logic signed [ACC_W-1:0] acc;

    tvcm_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    // Cross product term schedule: two products per component, then dot.
    // Step s (0..5) builds c[s/2]; steps 0..2 of ST_DOT accumulate D.
    logic signed [EW-1:0] xa, xb;
    always_comb
    begin
        xa = e_reg[4];
        xb = e_reg[8];
        case (step_reg)
            4'd0: begin xa = e_reg[4]; xb = e_reg[8]; end
            4'd1: begin xa = e_reg[5]; xb = e_reg[7]; end
            4'd2: begin xa = e_reg[5]; xb = e_reg[6]; end
            4'd3: begin xa = e_reg[3]; xb = e_reg[8]; end
            4'd4: begin xa = e_reg[3]; xb = e_reg[7]; end
            4'd5: begin xa = e_reg[4]; xb = e_reg[6]; end
            default: begin xa = e_reg[4]; xb = e_reg[8]; end
        endcase
    end

    logic [1:0] didx;
    assign didx = step_reg[1:0];

    // One 16-bit digit of the division by 6 per cycle. The digit quotient
    // comes from a reciprocal multiply, exact for every value below 2^19.
    logic [18:0] div_v;
    logic [39:0] div_p;
    logic [15:0] div_qd;
    logic [18:0] div_rem;
    assign div_v   = {r_reg, mag_reg[DW-1 -: 16]};
    assign div_p   = 40'(div_v) * 40'(349526);
    assign div_qd  = div_p[36:21];
    assign div_rem = div_v - 19'(div_qd) * 19'd6;

    // Fraction bits from the final remainder: floor(r * 2^F / 6).
    logic [7:0] frac;
    always_comb
    begin
        case (r_reg)
            3'd1: frac = 8'((1 << VOLUME_FRAC_BITS) / 6);
            3'd2: frac = 8'((2 << VOLUME_FRAC_BITS) / 6);
            3'd3: frac = 8'((3 << VOLUME_FRAC_BITS) / 6);
            3'd4: frac = 8'((4 << VOLUME_FRAC_BITS) / 6);
            3'd5: frac = 8'((5 << VOLUME_FRAC_BITS) / 6);
            default: frac = '0;
        endcase
    end

    logic signed [ACC_W-1:0] dabs;
    assign dabs = acc[ACC_W-1] ? -acc : acc;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        ctrl.en    = 1'b0;
        ctrl.op    = OP_LOAD;
        mac_a      = '0;
        mac_b      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                step_next  = '0;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                ctrl.en = 1'b1;
                ctrl.op = step_reg[0] ? OP_SUB : OP_LOAD;
                mac_a   = 34'(xa);
                mac_b   = 34'(xb);
                if (step_reg == 4'd6)
                begin
                    ctrl.en    = 1'b0;
                    step_next  = '0;
                    state_next = ST_DOT;
                end
                else
                    step_next = step_reg + 4'd1;
            end
            ST_DOT:
            begin
                if (step_reg == 4'd3)
                begin
                    step_next  = '0;
                    bit_next   = 3'(DW / 16);
                    q_next     = '0;
                    r_next     = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    ctrl.en   = 1'b1;
                    ctrl.op   = (step_reg == 4'd0) ? OP_LOAD : OP_ADD;
                    mac_a     = 34'(e_reg[{2'b00, didx}]);
                    mac_b     = c_reg[didx];
                    step_next = step_reg + 4'd1;
                end
            end
            ST_DIV:
            begin
                if (bit_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    q_next   = {q_reg[DW-17:0], div_qd};
                    r_next   = div_rem[2:0];
                    bit_next = bit_reg - 3'd1;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            p_reg[0]  <= v0_x; p_reg[1]  <= v0_y; p_reg[2]  <= v0_z;
            p_reg[3]  <= v1_x; p_reg[4]  <= v1_y; p_reg[5]  <= v1_z;
            p_reg[6]  <= v2_x; p_reg[7]  <= v2_y; p_reg[8]  <= v2_z;
            p_reg[9]  <= v3_x; p_reg[10] <= v3_y; p_reg[11] <= v3_z;
        end
        if (state_reg == ST_DIFF)
        begin
            for (int i = 0; i < 9; i++)
                e_reg[i] <= EW'(p_reg[i + 3]) - EW'(p_reg[i % 3]);
        end
        // The product is registered in the accumulator and read in the next step; odd steps close a component.
        if (state_reg == ST_CROSS && step_reg != 4'd0 && !step_reg[0])
            c_reg[step_reg[2:1] - 2'd1] <= acc[33:0];
        if (state_reg == ST_DOT && step_reg == 4'd3)
            mag_reg <= dabs[DW-1:0];
        else if (state_reg == ST_DIV && bit_reg != '0)
            mag_reg <= {mag_reg[DW-17:0], 16'h0000};
        if (state_reg == ST_DIV && bit_reg == '0)
        begin
            if (q_reg[DW-1:VOL_WIDTH-VOLUME_FRAC_BITS] != '0)
                vol_reg <= '1;
            else
                vol_reg <= (VOL_WIDTH'(q_reg) << VOLUME_FRAC_BITS) + VOL_WIDTH'(frac);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign volume    = vol_reg;

    ap_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while input open");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(volume)))
        else $error("result dropped under stall");
    ap_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DIFF))
        else $error("accepted transaction not started");

endmodule

>>> bench/tetrahedron_volume_cayley_menger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetrahedron_volume_cayley_menger_tb: volume checker for the tetrahedron block
// Drives vertex sets through the valid/stall input channel and compares each
// volume with floor(|triple product| * 2^F / 6), computed exactly here.
// ----------------------------------------------------------------------------
module tetrahedron_volume_cayley_menger_tb;

    localparam int CB = tvcm_pkg::COORD_BITS;
    localparam int FB = tvcm_pkg::VOLUME_FRAC_BITS_DEF;
    localparam int VW = tvcm_pkg::VOL_WIDTH;

    typedef logic signed [CB-1:0] coord_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    coord_t crd [12];
    logic out_valid;
    logic out_stall;
    logic [VW-1:0] volume;

    logic [VW-1:0] volume_q[$];
    int errors = 0;
    int checked = 0;
    int zero_vols = 0;
    bit idle_on = 1;
    bit hold_off = 0;

    tetrahedron_volume_cayley_menger DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .v0_x(crd[0]), .v0_y(crd[1]), .v0_z(crd[2]),
        .v1_x(crd[3]), .v1_y(crd[4]), .v1_z(crd[5]),
        .v2_x(crd[6]), .v2_y(crd[7]), .v2_z(crd[8]),
        .v3_x(crd[9]), .v3_y(crd[10]), .v3_z(crd[11]),
        .out_valid(out_valid), .out_stall(out_stall), .volume(volume)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // Exact volume: |D| / 6 in fixed point, saturated to the output width.
    function automatic logic [VW-1:0] tet_volume(input coord_t p [12]);
        longint e [9];
        longint cx, cy, cz, d;
        logic [63:0] mag, q, r;
        for (int i = 0; i < 9; i++)
            e[i] = longint'(p[i + 3]) - longint'(p[i % 3]);
        cx = e[4] * e[8] - e[5] * e[7];
        cy = e[5] * e[6] - e[3] * e[8];
        cz = e[3] * e[7] - e[4] * e[6];
        d = e[0] * cx + e[1] * cy + e[2] * cz;
        mag = (d < 0) ? -d : d;
        q = mag / 6;
        r = mag % 6;
        if ((q >> (VW - FB)) != 0)
            return '1;
        return VW'((q << FB) + ((r << FB) / 6));
    endfunction

    task automatic send_tet(input coord_t p [12]);
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 17)) @(negedge clk);
        crd = p;
        in_valid = 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        volume_q.push_back(tet_volume(p));
        @(negedge clk);
        in_valid = 0;
    endtask

    // Receiver stall pattern.
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_stall <= 1;
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 0;
            end
            else
                out_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (volume_q.size() == 0)
            begin
                $error("volume: unexpected result %0d", volume);
                errors++;
            end
            else
            begin
                logic [VW-1:0] exp_vol;
                exp_vol = volume_q.pop_front();
                if (volume !== exp_vol)
                begin
                    $error("volume: expected %0d, actual %0d", exp_vol, volume);
                    errors++;
                end
                if (exp_vol == 0)
                    zero_vols++;
                checked++;
            end
        end
    end

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(-(1 << (CB - 1)));
            1: return coord_t'((1 << (CB - 1)) - 1);
            2: return coord_t'(int'($urandom_range(0, 15)) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        coord_t p [12];
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < 12; i++)
                p[i] = '0;
            // Axis-aligned corner tetrahedra spanning the full coordinate range.
            p[0] = k[0] ? coord_t'(-(1 << (CB - 1))) : '0;
            p[1] = k[1] ? coord_t'(-(1 << (CB - 1))) : '0;
            p[2] = k[2] ? coord_t'(-(1 << (CB - 1))) : '0;
            p[3] = coord_t'((1 << (CB - 1)) - 1);
            p[7] = coord_t'((1 << (CB - 1)) - 1);
            p[11] = coord_t'((1 << (CB - 1)) - 1);
            send_tet(p);
        end
        // Unit tetrahedron, its mirror, and a pattern alternating the maximum and -1.
        for (int i = 0; i < 12; i++)
            p[i] = '0;
        p[3] = coord_t'(1); p[7] = coord_t'(1); p[11] = coord_t'(1);
        send_tet(p);
        p[3] = coord_t'(-1);
        send_tet(p);
        for (int i = 0; i < 12; i++)
            p[i] = (i % 2) ? '1 : coord_t'((1 << (CB - 1)) - 1);
        send_tet(p);
    endtask

    task automatic test_degenerate();
        coord_t p [12];
        // Repeated vertex, then four coplanar points, then all equal.
        for (int i = 0; i < 12; i++)
            p[i] = rnd_coord();
        for (int i = 0; i < 3; i++)
            p[9 + i] = p[3 + i];
        send_tet(p);
        for (int i = 0; i < 12; i++)
            p[i] = (i % 3 == 2) ? coord_t'(77) : rnd_coord();
        send_tet(p);
        for (int i = 0; i < 12; i++)
            p[i] = coord_t'(-5);
        send_tet(p);
    endtask

    task automatic test_orientation();
        coord_t p [12];
        coord_t t;
        for (int n = 0; n < 4; n++)
        begin
            for (int i = 0; i < 12; i++)
                p[i] = coord_t'(int'($urandom_range(0, 2000)) - 1000);
            send_tet(p);
            // Swapping two vertices flips the sign of D only.
            for (int i = 0; i < 3; i++)
            begin
                t = p[i];
                p[i] = p[3 + i];
                p[3 + i] = t;
            end
            send_tet(p);
        end
    endtask

    task automatic test_backpressure();
        coord_t p [12];
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            for (int n = 0; n < 4; n++)
            begin
                for (int i = 0; i < 12; i++)
                    p[i] = rnd_coord();
                send_tet(p);
            end
        join
    endtask

    task automatic test_random(input int count);
        coord_t p [12];
        for (int n = 0; n < count; n++)
        begin
            if (n == count * 4 / 5)
                idle_on = 0;
            for (int i = 0; i < 12; i++)
                p[i] = rnd_coord();
            // Some degenerate sets mixed into the random traffic.
            if ($urandom_range(0, 15) == 0)
                for (int i = 0; i < 3; i++)
                    p[6 + i] = p[i];
            send_tet(p);
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 0;
        in_valid = 0;
        for (int i = 0; i < 12; i++)
            crd[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        test_extremes();
        test_degenerate();
        test_orientation();
        test_backpressure();
        test_random(1880);

        waited = 0;
        while (volume_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (volume_q.size() != 0)
        begin
            $error("volume: %0d results never arrived", volume_q.size());
            errors++;
        end
        $display("Checked %0d volumes (%0d zero) over extremes, degenerate,",
                 checked, zero_vols);
        $display("orientation, held-off output and random vertex sets.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> tetrahedron_volume_cayley_menger.f
rtl/tvcm_pkg.sv
rtl/tvcm_mac.sv
rtl/tetrahedron_volume_cayley_menger.sv
bench/tetrahedron_volume_cayley_menger_tb.sv
